// ----- src/jotp_pkg.sv -----
// Shared types and constants for the JSON object token parser.
package jotp_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef enum logic [3:0] {
        CL_BLANK  = 4'd0,
        CL_LBRACE = 4'd1,
        CL_RBRACE = 4'd2,
        CL_LBRACK = 4'd3,
        CL_RBRACK = 4'd4,
        CL_QUOTE  = 4'd5,
        CL_BSLASH = 4'd6,
        CL_COLON  = 4'd7,
        CL_COMMA  = 4'd8,
        CL_DIGIT  = 4'd9,
        CL_DOT    = 4'd10,
        CL_MINUS  = 4'd11,
        CL_T      = 4'd12,
        CL_F      = 4'd13,
        CL_N      = 4'd14,
        CL_OTHER  = 4'd15
    } t_cls;

    typedef struct packed {
        logic [7:0] byte_val;
        logic       last;
        t_cls       cls;
    } t_qent;

    typedef enum logic [3:0] {
        EV_NONE     = 4'd0,
        EV_KEYCHAR  = 4'd1,
        EV_KEYEND   = 4'd2,
        EV_STRCHAR  = 4'd3,
        EV_STREND   = 4'd4,
        EV_NUMCHAR  = 4'd5,
        EV_NUMEND   = 4'd6,
        EV_TRUE     = 4'd7,
        EV_FALSE    = 4'd8,
        EV_NULL     = 4'd9,
        EV_OPEN     = 4'd10,
        EV_CLOSE    = 4'd11,
        EV_NUMCLOSE = 4'd12
    } t_event;

    localparam logic [1:0] STAT_RUN  = 2'd0;
    localparam logic [1:0] STAT_DONE = 2'd1;
    localparam logic [1:0] STAT_ERR  = 2'd2;

    localparam logic [1:0] LIT_TRUE  = 2'd0;
    localparam logic [1:0] LIT_FALSE = 2'd1;
    localparam logic [1:0] LIT_NULL  = 2'd2;

    typedef enum logic [12:0] {
        ST_START     = 13'b0000000000001,
        ST_KEY_OPEN  = 13'b0000000000010,
        ST_IN_KEY    = 13'b0000000000100,
        ST_COLON     = 13'b0000000001000,
        ST_VALUE     = 13'b0000000010000,
        ST_ARRAY     = 13'b0000000100000,
        ST_LITERAL   = 13'b0000001000000,
        ST_NUMBER    = 13'b0000010000000,
        ST_STRING    = 13'b0000100000000,
        ST_CLOSE_COM = 13'b0001000000000,
        ST_COMMA_END = 13'b0010000000000,
        ST_DONE      = 13'b0100000000000,
        ST_ERROR     = 13'b1000000000000
    } t_state;

    function automatic logic [2:0] lit_len(input logic [1:0] kind);
        logic [2:0] len;
        unique case (kind)
            LIT_FALSE: len = 3'd5;
            default:   len = 3'd4;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (kind)
            LIT_TRUE: begin
                unique case (pos)
                    3'd0: ch = "t";
                    3'd1: ch = "r";
                    3'd2: ch = "u";
                    3'd3: ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            LIT_FALSE: begin
                unique case (pos)
                    3'd0: ch = "f";
                    3'd1: ch = "a";
                    3'd2: ch = "l";
                    3'd3: ch = "s";
                    3'd4: ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            LIT_NULL: begin
                unique case (pos)
                    3'd0: ch = "n";
                    3'd1: ch = "u";
                    3'd2: ch = "l";
                    3'd3: ch = "l";
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ----- src/jotp_front.sv -----
// Front end: classify each incoming byte and push it toward the queue.
module jotp_front (
    input  logic                  i_valid,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_last,
    input  logic                  i_q_full,
    output logic                  o_stall,
    output logic                  o_push,
    output jotp_pkg::t_qent       o_ent
);
    import jotp_pkg::*;

    t_cls cls;

    always_comb begin
        priority if (i_data_byte == 8'd32 || (i_data_byte >= 8'd9 && i_data_byte <= 8'd13)) begin
            cls = CL_BLANK;
        end else if (i_data_byte >= "0" && i_data_byte <= "9") begin
            cls = CL_DIGIT;
        end else begin
            unique case (i_data_byte)
                "{":     cls = CL_LBRACE;
                "}":     cls = CL_RBRACE;
                "[":     cls = CL_LBRACK;
                "]":     cls = CL_RBRACK;
                "\"":    cls = CL_QUOTE;
                "\\":    cls = CL_BSLASH;
                ":":     cls = CL_COLON;
                ",":     cls = CL_COMMA;
                ".":     cls = CL_DOT;
                "-":     cls = CL_MINUS;
                "t":     cls = CL_T;
                "f":     cls = CL_F;
                "n":     cls = CL_N;
                default: cls = CL_OTHER;
            endcase
        end
    end

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;
    assign o_ent   = '{byte_val: i_data_byte, last: i_last, cls: cls};

endmodule

// ----- src/jotp_queue.sv -----
// Short queue of classified bytes between front and back ends.
module jotp_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  jotp_pkg::t_qent          i_ent,
    input  logic                     i_pop,
    output logic                     o_full,
    output logic                     o_nonempty,
    output jotp_pkg::t_qent          o_ent,
    output logic [jotp_pkg::QCW-1:0] o_level
);
    import jotp_pkg::*;

    t_qent            r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp, n_wp;
    logic [QAW-1:0]   r_rp, n_rp;
    logic [QCW-1:0]   r_cnt, n_cnt;
    logic             do_pop;

    assign o_full     = (r_cnt == QCW'(QDEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_ent      = r_mem[r_rp];
    assign o_level    = r_cnt;
    assign do_pop     = i_pop && o_nonempty;

    always_comb begin
        n_wp  = i_push ? r_wp + 1'b1 : r_wp;
        n_rp  = do_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + QCW'(i_push) - QCW'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_ent;
        end
    end

endmodule

// ----- src/jotp_back.sv -----
// Back end: grammar state machine, depth counter and registered result.
module jotp_back #(
    parameter int MAX_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_nonempty,
    input  jotp_pkg::t_qent   i_ent,
    output logic              o_pop,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [3:0]        o_event_res,
    output logic [7:0]        o_char_out,
    output logic [4:0]        o_depth,
    output logic [1:0]        o_status
);
    import jotp_pkg::*;

    localparam int DW = $clog2(MAX_DEPTH + 1);

    t_state          r_state, n_state;
    logic            r_esc, n_esc;
    logic            r_dot, n_dot;
    logic [1:0]      r_kind, n_kind;
    logic [2:0]      r_pos, n_pos;
    logic [DW-1:0]   r_depth, n_depth;
    logic            r_ov;
    logic [3:0]      r_ev;
    logic [7:0]      r_ch;
    logic [4:0]      r_dep;
    logic [1:0]      r_stat;

    t_event          ev;
    logic            take;
    logic [DW-1:0]   dec_depth;
    t_state          after_cur;
    t_state          after_dec;
    logic            lit_ok;
    logic [2:0]      pos_inc;
    logic [7:0]      ch;
    logic [1:0]      stat;

    assign take = i_q_nonempty && (!r_ov || !i_stall);
    assign o_pop = take;

    always_comb begin
        n_state   = r_state;
        n_esc     = r_esc;
        n_dot     = r_dot;
        n_kind    = r_kind;
        n_pos     = r_pos;
        n_depth   = r_depth;
        ev        = EV_NONE;
        dec_depth = r_depth - DW'(r_depth != '0);
        after_cur = (r_depth != '0) ? ST_CLOSE_COM : ST_COMMA_END;
        after_dec = (dec_depth != '0) ? ST_CLOSE_COM : ST_COMMA_END;
        pos_inc   = r_pos + 3'd1;
        lit_ok    = (r_pos < lit_len(r_kind)) && (lit_char(r_kind, r_pos) == i_ent.byte_val);

        if (r_state == ST_DONE || r_state == ST_ERROR) begin
            n_state = r_state;
        end else if (i_ent.cls == CL_BLANK && r_state != ST_IN_KEY
                     && r_state != ST_STRING) begin
            n_state = r_state;
        end else begin
            unique case (r_state)
                ST_START: begin
                    n_state = (i_ent.cls == CL_LBRACE) ? ST_KEY_OPEN : ST_ERROR;
                end
                ST_KEY_OPEN: begin
                    priority if (i_ent.cls == CL_RBRACE) begin
                        n_state = ST_DONE;
                    end else if (i_ent.cls == CL_QUOTE) begin
                        n_esc   = 1'b0;
                        n_state = ST_IN_KEY;
                    end else begin
                        n_state = ST_ERROR;
                    end
                end
                ST_IN_KEY, ST_STRING: begin
                    priority if (r_esc) begin
                        n_esc = 1'b0;
                        ev    = (r_state == ST_IN_KEY) ? EV_KEYCHAR : EV_STRCHAR;
                    end else if (i_ent.cls == CL_BSLASH) begin
                        n_esc = 1'b1;
                    end else if (i_ent.cls == CL_QUOTE) begin
                        if (r_state == ST_IN_KEY) begin
                            n_state = ST_COLON;
                            ev      = EV_KEYEND;
                        end else begin
                            n_state = after_cur;
                            ev      = EV_STREND;
                        end
                    end else begin
                        ev = (r_state == ST_IN_KEY) ? EV_KEYCHAR : EV_STRCHAR;
                    end
                end
                ST_COLON: begin
                    n_state = (i_ent.cls == CL_COLON) ? ST_VALUE : ST_ERROR;
                end
                ST_VALUE, ST_ARRAY: begin
                    if (r_state == ST_ARRAY && i_ent.cls == CL_RBRACK) begin
                        n_depth = dec_depth;
                        n_state = after_dec;
                        ev      = EV_CLOSE;
                    end else begin
                        unique case (i_ent.cls)
                            CL_QUOTE: begin
                                n_esc   = 1'b0;
                                n_state = ST_STRING;
                            end
                            CL_T, CL_F, CL_N: begin
                                n_kind  = (i_ent.cls == CL_T) ? LIT_TRUE :
                                          (i_ent.cls == CL_F) ? LIT_FALSE : LIT_NULL;
                                n_pos   = 3'd1;
                                n_state = ST_LITERAL;
                            end
                            CL_MINUS, CL_DIGIT: begin
                                n_dot   = 1'b0;
                                n_state = ST_NUMBER;
                                ev      = EV_NUMCHAR;
                            end
                            CL_LBRACK: begin
                                if (r_depth >= DW'(MAX_DEPTH)) begin
                                    n_state = ST_ERROR;
                                end else begin
                                    n_depth = r_depth + DW'(1);
                                    n_state = ST_ARRAY;
                                    ev      = EV_OPEN;
                                end
                            end
                            default: n_state = ST_ERROR;
                        endcase
                    end
                end
                ST_LITERAL: begin
                    if (lit_ok) begin
                        n_pos = pos_inc;
                        if (pos_inc == lit_len(r_kind)) begin
                            unique case (r_kind)
                                LIT_TRUE:  ev = EV_TRUE;
                                LIT_FALSE: ev = EV_FALSE;
                                default:   ev = EV_NULL;
                            endcase
                            n_pos   = 3'd0;
                            n_state = after_cur;
                        end
                    end else begin
                        n_state = ST_ERROR;
                    end
                end
                ST_NUMBER: begin
                    priority if (i_ent.cls == CL_DIGIT) begin
                        ev = EV_NUMCHAR;
                    end else if (i_ent.cls == CL_DOT) begin
                        if (r_dot) begin
                            n_state = ST_ERROR;
                        end else begin
                            n_dot = 1'b1;
                            ev    = EV_NUMCHAR;
                        end
                    end else if (r_depth == '0) begin
                        priority if (i_ent.cls == CL_COMMA) begin
                            n_state = ST_KEY_OPEN;
                            ev      = EV_NUMEND;
                        end else if (i_ent.cls == CL_RBRACE) begin
                            n_state = ST_DONE;
                            ev      = EV_NUMEND;
                        end else begin
                            n_state = ST_ERROR;
                        end
                    end else begin
                        priority if (i_ent.cls == CL_COMMA) begin
                            n_state = ST_ARRAY;
                            ev      = EV_NUMEND;
                        end else if (i_ent.cls == CL_RBRACK) begin
                            n_depth = dec_depth;
                            n_state = after_dec;
                            ev      = EV_NUMCLOSE;
                        end else begin
                            n_state = ST_ERROR;
                        end
                    end
                end
                ST_CLOSE_COM: begin
                    priority if (i_ent.cls == CL_RBRACK) begin
                        n_depth = dec_depth;
                        n_state = after_dec;
                        ev      = EV_CLOSE;
                    end else if (i_ent.cls == CL_COMMA) begin
                        n_state = ST_ARRAY;
                    end else begin
                        n_state = ST_ERROR;
                    end
                end
                ST_COMMA_END: begin
                    priority if (i_ent.cls == CL_COMMA) begin
                        n_state = ST_KEY_OPEN;
                    end else if (i_ent.cls == CL_RBRACE) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_ERROR;
                    end
                end
                default: n_state = ST_ERROR;
            endcase
        end

        if (i_ent.last && n_state != ST_DONE) begin
            n_state = ST_ERROR;
        end

        ch = (ev == EV_KEYCHAR || ev == EV_STRCHAR || ev == EV_NUMCHAR) ?
             i_ent.byte_val : 8'h00;
        stat = (n_state == ST_DONE) ? STAT_DONE :
               (n_state == ST_ERROR) ? STAT_ERR : STAT_RUN;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_START;
            r_esc   <= 1'b0;
            r_dot   <= 1'b0;
            r_kind  <= 2'd0;
            r_pos   <= 3'd0;
            r_depth <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (take) begin
                r_state <= n_state;
                r_esc   <= n_esc;
                r_dot   <= n_dot;
                r_kind  <= n_kind;
                r_pos   <= n_pos;
                r_depth <= n_depth;
                r_ov    <= 1'b1;
            end else if (!i_stall) begin
                r_ov    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_ev   <= ev;
            r_ch   <= ch;
            r_dep  <= 5'(n_depth);
            r_stat <= stat;
        end
    end

    assign o_valid     = r_ov;
    assign o_event_res = r_ev;
    assign o_char_out  = r_ch;
    assign o_depth     = r_dep;
    assign o_status    = r_stat;

endmodule

// ----- src/json_object_token_parser_core.sv -----
// Top level of the JSON object token parser: front end, queue and back end.
// Takes one byte of a flat JSON object per transfer and returns one token
// transfer per byte, in order: the event, the byte for character events, the
// array depth after the byte and a running/complete/error status. One byte per
// clock is sustained while the output side does not stall. A byte lands in the
// four-entry queue, and the grammar state machine reads the queue head directly
// and loads its result register, from which the byte's result is offered.
// The input stalls only while the queue is full, and the queue fills only while
// the output side stalls. Once complete or in error the block stays so until
// reset. Arrays nest up to MAX_DEPTH levels.
module json_object_token_parser_core #(
    parameter int MAX_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [3:0] o_event_res,
    output logic [7:0] o_char_out,
    output logic [4:0] o_depth,
    output logic [1:0] o_status
);
    import jotp_pkg::*;

    t_qent            f_ent;
    t_qent            q_ent;
    logic             f_push;
    logic             q_full;
    logic             q_nonempty;
    logic             b_pop;
    logic [QCW-1:0]   q_level;

    jotp_front u_front (
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .i_last      (i_last),
        .i_q_full    (q_full),
        .o_stall     (o_stall),
        .o_push      (f_push),
        .o_ent       (f_ent)
    );

    jotp_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (f_push),
        .i_ent      (f_ent),
        .i_pop      (b_pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_ent      (q_ent),
        .o_level    (q_level)
    );

    jotp_back #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_nonempty (q_nonempty),
        .i_ent        (q_ent),
        .o_pop        (b_pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_event_res  (o_event_res),
        .o_char_out   (o_char_out),
        .o_depth      (o_depth),
        .o_status     (o_status)
    );

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_level <= QCW'(QDEPTH))
        else $error("queue level exceeds depth");

    a_pop_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_pop |=> o_valid)
        else $error("popped byte produced no result");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (q_level == QCW'(QDEPTH)) && $past(o_valid))
        else $error("input stalled without a full queue");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (MAX_DEPTH > 31) || (o_depth <= 5'(MAX_DEPTH)))
        else $error("depth beyond limit");

    a_char_only_chars: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_event_res != EV_KEYCHAR && o_event_res != EV_STRCHAR
         && o_event_res != EV_NUMCHAR) |-> (o_char_out == 8'h00))
        else $error("char output on a non-character event");

endmodule

// ----- sim/json_object_token_parser_core_tb.sv -----
// Self-checking testbench for the JSON object token parser core.
`timescale 1ns / 1ps

module json_object_token_parser_core_tb;
    import jotp_pkg::*;

    localparam int DEPTH_LIMIT = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TEXT_BYTES  = 1150;
    localparam int CALM_FROM   = 900;
    localparam int CALM_TO     = 1300;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_LEN    = 80;

    typedef struct packed {
        logic [7:0] data;
        logic       lst;
        logic       hold;
    } t_text_byte;

    typedef struct {
        t_event     ev;
        logic [7:0] ch;
        logic [4:0] dep;
        logic [1:0] st;
    } t_token;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_last = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [3:0] o_event_res;
    logic [7:0] o_char_out;
    logic [4:0] o_depth;
    logic [1:0] o_status;

    t_text_byte bytes_to_send[$];
    t_token     tokens_due[$];
    int         cycle_count = 0;
    int         hold_left = 0;
    int         mismatches = 0;
    bit         pause_next = 1'b0;

    t_state     ps = ST_START;
    bit         esc = 1'b0;
    bit         dot = 1'b0;
    logic [1:0] lkind = LIT_TRUE;
    logic [2:0] lpos = 3'd0;
    int         adepth = 0;

    json_object_token_parser_core #(
        .MAX_DEPTH(DEPTH_LIMIT)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data_byte(i_data_byte),
        .i_last(i_last),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_event_res(o_event_res),
        .o_char_out(o_char_out),
        .o_depth(o_depth),
        .o_status(o_status)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit is_blank(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [2:0] lit_span(input logic [1:0] kind);
        return (kind == LIT_FALSE) ? 3'd5 : 3'd4;
    endfunction

    function automatic logic [7:0] lit_byte(input logic [1:0] kind, input logic [2:0] pos);
        logic [39:0] word;
        case (kind)
            LIT_TRUE:  word = {"true", 8'h00};
            LIT_FALSE: word = "false";
            default:   word = {"null", 8'h00};
        endcase
        return word[39 - 8 * int'(pos) -: 8];
    endfunction

    function automatic t_state after_value();
        return (adepth != 0) ? ST_CLOSE_COM : ST_COMMA_END;
    endfunction

    function automatic void shut_array();
        if (adepth != 0) adepth--;
        ps = after_value();
    endfunction

    function automatic t_event open_value(input logic [7:0] c);
        t_event e;
        e = EV_NONE;
        if (c == "\"") begin
            esc = 1'b0;
            ps = ST_STRING;
        end else if (c == "t" || c == "f" || c == "n") begin
            lkind = (c == "t") ? LIT_TRUE : (c == "f") ? LIT_FALSE : LIT_NULL;
            lpos = 3'd1;
            ps = ST_LITERAL;
        end else if (c == "-" || is_digit(c)) begin
            dot = 1'b0;
            ps = ST_NUMBER;
            e = EV_NUMCHAR;
        end else if (c == "[") begin
            if (adepth >= DEPTH_LIMIT) begin
                ps = ST_ERROR;
            end else begin
                adepth++;
                ps = ST_ARRAY;
                e = EV_OPEN;
            end
        end else begin
            ps = ST_ERROR;
        end
        return e;
    endfunction

    task automatic tokenize(input logic [7:0] c, input logic lst);
        t_event ev;
        t_token tk;
        ev = EV_NONE;
        if (ps == ST_DONE || ps == ST_ERROR) begin
        end else if (is_blank(c) && ps != ST_IN_KEY && ps != ST_STRING) begin
        end else begin
            case (ps)
                ST_START: ps = (c == "{") ? ST_KEY_OPEN : ST_ERROR;
                ST_KEY_OPEN: begin
                    if (c == "}") begin
                        ps = ST_DONE;
                    end else if (c == "\"") begin
                        esc = 1'b0;
                        ps = ST_IN_KEY;
                    end else begin
                        ps = ST_ERROR;
                    end
                end
                ST_IN_KEY: begin
                    if (esc) begin
                        esc = 1'b0;
                        ev = EV_KEYCHAR;
                    end else if (c == "\\") begin
                        esc = 1'b1;
                    end else if (c == "\"") begin
                        ps = ST_COLON;
                        ev = EV_KEYEND;
                    end else begin
                        ev = EV_KEYCHAR;
                    end
                end
                ST_COLON: ps = (c == ":") ? ST_VALUE : ST_ERROR;
                ST_VALUE: ev = open_value(c);
                ST_ARRAY: begin
                    if (c == "]") begin
                        shut_array();
                        ev = EV_CLOSE;
                    end else begin
                        ev = open_value(c);
                    end
                end
                ST_LITERAL: begin
                    if (lpos < lit_span(lkind) && lit_byte(lkind, lpos) == c) begin
                        lpos++;
                        if (lpos == lit_span(lkind)) begin
                            case (lkind)
                                LIT_TRUE:  ev = EV_TRUE;
                                LIT_FALSE: ev = EV_FALSE;
                                default:   ev = EV_NULL;
                            endcase
                            lpos = 3'd0;
                            ps = after_value();
                        end
                    end else begin
                        ps = ST_ERROR;
                    end
                end
                ST_NUMBER: begin
                    if (is_digit(c) || c == ".") begin
                        if (c == "." && dot) begin
                            ps = ST_ERROR;
                        end else begin
                            if (c == ".") dot = 1'b1;
                            ev = EV_NUMCHAR;
                        end
                    end else if (adepth == 0) begin
                        if (c == ",") begin
                            ps = ST_KEY_OPEN;
                            ev = EV_NUMEND;
                        end else if (c == "}") begin
                            ps = ST_DONE;
                            ev = EV_NUMEND;
                        end else begin
                            ps = ST_ERROR;
                        end
                    end else begin
                        if (c == ",") begin
                            ps = ST_ARRAY;
                            ev = EV_NUMEND;
                        end else if (c == "]") begin
                            shut_array();
                            ev = EV_NUMCLOSE;
                        end else begin
                            ps = ST_ERROR;
                        end
                    end
                end
                ST_STRING: begin
                    if (esc) begin
                        esc = 1'b0;
                        ev = EV_STRCHAR;
                    end else if (c == "\\") begin
                        esc = 1'b1;
                    end else if (c == "\"") begin
                        ps = after_value();
                        ev = EV_STREND;
                    end else begin
                        ev = EV_STRCHAR;
                    end
                end
                ST_CLOSE_COM: begin
                    if (c == "]") begin
                        shut_array();
                        ev = EV_CLOSE;
                    end else if (c == ",") begin
                        ps = ST_ARRAY;
                    end else begin
                        ps = ST_ERROR;
                    end
                end
                ST_COMMA_END: begin
                    if (c == ",") ps = ST_KEY_OPEN;
                    else if (c == "}") ps = ST_DONE;
                    else ps = ST_ERROR;
                end
                default: ps = ST_ERROR;
            endcase
        end
        if (lst && ps != ST_DONE) ps = ST_ERROR;

        tk.ev  = ev;
        tk.ch  = (ev == EV_KEYCHAR || ev == EV_STRCHAR || ev == EV_NUMCHAR) ? c : 8'h00;
        tk.dep = adepth[4:0];
        tk.st  = (ps == ST_DONE) ? STAT_DONE : (ps == ST_ERROR) ? STAT_ERR : STAT_RUN;
        tokens_due.insert(tokens_due.size(), tk);
    endtask

    task automatic check_token();
        t_token tk;
        if (tokens_due.size() == 0) begin
            $error("token transfer with none expected: event %0d", o_event_res);
            mismatches++;
        end else begin
            tk = tokens_due.pop_front();
            if (o_event_res !== tk.ev) begin
                $error("event_res: expected %0d, actual %0d", tk.ev, o_event_res);
                mismatches++;
            end
            if (o_char_out !== tk.ch) begin
                $error("char_out: expected %0d, actual %0d", tk.ch, o_char_out);
                mismatches++;
            end
            if (o_depth !== tk.dep) begin
                $error("depth: expected %0d, actual %0d", tk.dep, o_depth);
                mismatches++;
            end
            if (o_status !== tk.st) begin
                $error("status: expected %0d, actual %0d", tk.st, o_status);
                mismatches++;
            end
        end
    endtask

    function automatic bit calm();
        return cycle_count >= CALM_FROM && cycle_count < CALM_TO;
    endfunction

    function automatic bit idle_now();
        return !calm() && $urandom_range(0, 99) < 29;
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("json_object_token_parser_core_tb: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                tokenize(i_data_byte, i_last);
            end
            if (!i_valid || !o_stall) begin
                if (bytes_to_send.size() == 0 || idle_now()) begin
                    i_valid <= 1'b0;
                end else if (bytes_to_send[0].hold && tokens_due.size() != 0) begin
                    i_valid <= 1'b0;
                end else begin
                    i_valid     <= 1'b1;
                    i_data_byte <= bytes_to_send[0].data;
                    i_last      <= bytes_to_send[0].lst;
                    void'(bytes_to_send.pop_front());
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                check_token();
            end
            if (hold_left != 0) begin
                i_stall   <= 1'b1;
                hold_left <= hold_left - 1;
            end else if (cycle_count == HOLD_AT) begin
                i_stall   <= 1'b1;
                hold_left <= HOLD_LEN - 1;
            end else begin
                i_stall <= idle_now();
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic lst = 1'b0);
        t_text_byte t;
        t.data = b;
        t.lst  = lst;
        t.hold = pause_next;
        pause_next = 1'b0;
        bytes_to_send.insert(bytes_to_send.size(), t);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    task automatic push_blanks();
        int r;
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 2)) begin
                r = $urandom_range(8, 13);
                push_byte((r == 8) ? 8'h20 : 8'(r));
            end
        end
    endtask

    task automatic push_digit();
        push_byte(8'(8'h30 + $urandom_range(0, 9)));
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        case ($urandom_range(0, 3))
            0:       b = 8'($urandom_range(128, 255));
            1:       b = 8'($urandom_range(0, 31));
            default: b = 8'($urandom_range(32, 126));
        endcase
        if (b == "\"" || b == "\\") b = "_";
        return b;
    endfunction

    task automatic push_quoted();
        push_byte("\"");
        repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 7) == 0) begin
                push_byte("\\");
                push_byte(8'($urandom_range(0, 255)));
            end else begin
                push_byte(text_byte());
            end
        end
        push_byte("\"");
    endtask

    task automatic push_number();
        if ($urandom_range(0, 1) == 0) push_byte("-");
        else push_digit();
        repeat ($urandom_range(0, 3)) begin
            push_blanks();
            push_digit();
        end
        if ($urandom_range(0, 2) == 0) begin
            push_byte(".");
            repeat ($urandom_range(0, 2)) push_digit();
        end
    endtask

    task automatic push_literal();
        case ($urandom_range(0, 2))
            0:       push_text("true");
            1:       push_text("false");
            default: push_text("null");
        endcase
    endtask

    task automatic push_value(input int d);
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) push_quoted();
        else if (r < 5) push_literal();
        else if (r < 8 || d >= 3) push_number();
        else push_array(d + 1, 1'b0);
    endtask

    task automatic push_array(input int d, input bit deep);
        int n;
        push_byte("[");
        push_blanks();
        if (deep) begin
            if (d < DEPTH_LIMIT) push_array(d + 1, 1'b1);
            else push_number();
            push_blanks();
        end else begin
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) begin
                if (i > 0) push_byte(",");
                push_blanks();
                push_value(d);
                push_blanks();
            end
            if (n > 0 && $urandom_range(0, 3) == 0) push_byte(",");
        end
        push_byte("]");
    endtask

    task automatic push_pair(input bit deep);
        push_blanks();
        push_quoted();
        push_blanks();
        push_byte(":");
        push_blanks();
        if (deep) push_array(1, 1'b1);
        else push_value(0);
        push_blanks();
    endtask

    initial begin
        int pairs;
        pairs = 0;

        push_text("{ \"k\\\"");
        push_byte(8'h0b);
        push_text("\":[-,1.5 ],\"\":\"");
        push_byte(8'hff);
        push_byte(8'h00);
        push_byte("\\");
        push_byte(8'h80);
        push_text("\",\"t\":true,");

        while (bytes_to_send.size() < TEXT_BYTES) begin
            pairs++;
            if (pairs == 40) pause_next = 1'b1;
            push_pair(pairs == 3);
            push_byte(",");
        end

        case ($urandom_range(0, 7))
            0: begin
                push_pair(1'b0);
                push_byte("}", 1'b1);
            end
            1: begin
                push_pair(1'b0);
                push_byte(" ");
                push_byte("}");
            end
            2: push_byte("}", 1'($urandom_range(0, 1)));
            3: begin
                push_pair(1'b0);
                push_byte("x");
            end
            4: begin
                push_text("\"d\":");
                repeat (DEPTH_LIMIT + 1) push_byte("[");
            end
            5: begin
                push_text("\"n\":");
                push_byte("7", 1'b1);
            end
            6: push_text("\"n\":1.2.");
            default: begin
                push_text("\"n\":-");
                push_byte(8'($urandom_range(128, 255)));
            end
        endcase
        repeat (16) push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (bytes_to_send.size() != 0 || i_valid) @(negedge i_clk);
        while (tokens_due.size() != 0) @(negedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatches == 0 && tokens_due.size() == 0) begin
            $display("json_object_token_parser_core_tb: PASS");
        end else begin
            $display("json_object_token_parser_core_tb: FAIL");
        end
        $finish;
    end

endmodule
